### rtl/tfs_pkg.sv
// Package for the taxonomy field splitter: default sizes, character codes,
// the attribute-name and level-letter lookups and the result word layout.
// Used by tfs_parser, taxonomy_field_splitter and the bench; depends on nothing.
package tfs_pkg;

   localparam int DEF_MAX_HEADER_BYTES = 65536;
   localparam int DEF_LEVEL_COUNT      = 9;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // Result word: level_index, level_found, name_offset, name_length, header_too_long
   localparam int RSP_FIELD_W = 4 + 1 + 16 + 16 + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef struct packed {
      logic       hit;
      logic [3:0] rank;
   } rank_type;

   // Characters of the attribute name "tax="
   function automatic logic [7:0] attr_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h74;  // t
         2'd1:    c = 8'h61;  // a
         2'd2:    c = 8'h78;  // x
         default: c = 8'h3D;  // =
      endcase
      return c;
   endfunction

   // Rank of a level letter d,k,p,c,o,f,g,s,t; only A..Z fold to lower case
   function automatic rank_type letter_rank(input logic [7:0] b);
      logic [7:0] low;
      rank_type   r;
      low = b;
      if (b inside {[8'h41:8'h5A]}) begin
         low = b + 8'd32;
      end
      r.hit = 1'b1;
      case (low)
         8'h64:   r.rank = 4'd0;  // d
         8'h6B:   r.rank = 4'd1;  // k
         8'h70:   r.rank = 4'd2;  // p
         8'h63:   r.rank = 4'd3;  // c
         8'h6F:   r.rank = 4'd4;  // o
         8'h66:   r.rank = 4'd5;  // f
         8'h67:   r.rank = 4'd6;  // g
         8'h73:   r.rank = 4'd7;  // s
         8'h74:   r.rank = 4'd8;  // t
         default: begin
            r.hit  = 1'b0;
            r.rank = 4'd0;
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/tfs_parser.sv
// Header parser: finds the first "tax=" attribute and records, per level,
// the name offset and length of each element of its value.
// Depends on tfs_pkg. Exposes the table as it stands after the current byte.
module tfs_parser #(
   parameter int MAX_HEADER_BYTES = tfs_pkg::DEF_MAX_HEADER_BYTES,
   parameter int LEVEL_COUNT      = tfs_pkg::DEF_LEVEL_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  header_byte,
   input  logic        final_byte,
   output logic [15:0] next_offset [LEVEL_COUNT],
   output logic [15:0] next_length [LEVEL_COUNT],
   output logic [LEVEL_COUNT-1:0] next_valid,
   output logic        next_overflow
);
   import tfs_pkg::*;

   localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);
   localparam int CMP_W = ((POS_W > 16) ? POS_W : 16) + 1;
   localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_LETTER = 2'd1;
   localparam logic [1:0] PH_NAME   = 2'd2;
   localparam logic [1:0] PH_SKIP   = 2'd3;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             tok_start_ff, tok_start_in;
   logic [1:0]       match_ff, match_in;
   logic             tax_seen_ff, tax_seen_in;
   logic             in_value_ff, in_value_in;
   logic [1:0]       phase_ff, phase_in;
   logic [LVL_W-1:0] pend_ff, pend_in;
   logic [LVL_W-1:0] rec_ff, rec_in;
   logic [15:0]      off_ff [LEVEL_COUNT];
   logic [15:0]      off_in [LEVEL_COUNT];
   logic [15:0]      len_ff [LEVEL_COUNT];
   logic [15:0]      len_in [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] vld_ff, vld_in;
   logic             ovf_ff, ovf_in;

   logic [POS_W-1:0] idx;
   logic [CMP_W-1:0] name_pos;
   rank_type         rank;
   logic             rank_ok;
   logic             active;

   always_comb begin
      pos_in       = pos_ff;
      tok_start_in = tok_start_ff;
      match_in     = match_ff;
      tax_seen_in  = tax_seen_ff;
      in_value_in  = in_value_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      rec_in       = rec_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      vld_in       = vld_ff;
      ovf_in       = ovf_ff;

      // Byte index saturates at the maximum header size
      if (pos_ff >= POS_W'(MAX_HEADER_BYTES)) begin
         idx    = POS_W'(MAX_HEADER_BYTES);
         ovf_in = 1'b1;
      end else begin
         idx    = pos_ff;
         pos_in = pos_ff + 1'b1;
      end

      name_pos = CMP_W'(idx) + 1'b1;
      rank     = letter_rank(header_byte);
      rank_ok  = rank.hit && (32'(rank.rank) < LEVEL_COUNT);
      active   = tok_start_ff || (match_ff != 2'd0);

      if (in_value_ff) begin
         if (header_byte == CHAR_SEMI) begin
            in_value_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (header_byte != CHAR_COMMA) begin
                     if (rank_ok) begin
                        pend_in  = LVL_W'(rank.rank);
                        phase_in = PH_LETTER;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_LETTER: begin
                  if (header_byte == CHAR_COLON) begin
                     if (name_pos > CMP_W'(SAT16)) begin
                        off_in[pend_ff] = SAT16;
                        ovf_in          = 1'b1;
                     end else begin
                        off_in[pend_ff] = name_pos[15:0];
                     end
                     len_in[pend_ff] = 16'd0;
                     vld_in[pend_ff] = 1'b1;
                     rec_in          = pend_ff;
                     phase_in        = PH_NAME;
                  end else if (header_byte == CHAR_COMMA) begin
                     phase_in = PH_START;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_NAME: begin
                  if (header_byte == CHAR_COMMA) begin
                     phase_in = PH_START;
                  end else if (len_ff[rec_ff] == SAT16) begin
                     ovf_in = 1'b1;
                  end else begin
                     len_in[rec_ff] = len_ff[rec_ff] + 16'd1;
                  end
               end
               default: begin
                  if (header_byte == CHAR_COMMA) begin
                     phase_in = PH_START;
                  end
               end
            endcase
         end
      end else if (!tax_seen_ff) begin
         // Match "tax=" only at header start or right after ';'
         if (active && (header_byte == attr_char(match_ff))) begin
            if (match_ff == 2'd3) begin
               match_in    = 2'd0;
               tax_seen_in = 1'b1;
               in_value_in = 1'b1;
               phase_in    = PH_START;
            end else begin
               match_in = match_ff + 2'd1;
            end
         end else begin
            match_in = 2'd0;
         end
         tok_start_in = (header_byte == CHAR_SEMI);
      end
   end

   // Clear everything on reset and after the last byte of a header
   always_ff @(posedge clock) begin
      if (reset || (byte_accept && final_byte)) begin
         pos_ff       <= '0;
         tok_start_ff <= 1'b1;
         match_ff     <= 2'd0;
         tax_seen_ff  <= 1'b0;
         in_value_ff  <= 1'b0;
         phase_ff     <= PH_START;
         pend_ff      <= '0;
         rec_ff       <= '0;
         vld_ff       <= '0;
         ovf_ff       <= 1'b0;
         for (int i = 0; i < LEVEL_COUNT; i++) begin
            off_ff[i] <= 16'd0;
            len_ff[i] <= 16'd0;
         end
      end else if (byte_accept) begin
         pos_ff       <= pos_in;
         tok_start_ff <= tok_start_in;
         match_ff     <= match_in;
         tax_seen_ff  <= tax_seen_in;
         in_value_ff  <= in_value_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         rec_ff       <= rec_in;
         vld_ff       <= vld_in;
         ovf_ff       <= ovf_in;
         off_ff       <= off_in;
         len_ff       <= len_in;
      end
   end

   assign next_offset   = off_in;
   assign next_length   = len_in;
   assign next_valid    = vld_in;
   assign next_overflow = ovf_in;

endmodule

### rtl/taxonomy_field_splitter.sv
// Taxonomy field splitter top level: byte parser plus a result buffer that
// plays out one result per level. Depends on tfs_pkg and tfs_parser.
//
// Usage:
//   req_*  carries the header text, one byte per request; req_tlast marks
//          the last byte of a header.
//   rsp_*  carries LEVEL_COUNT results per header, level 0 first;
//          rsp_tlast marks the result of the highest level.
//   A byte is taken in every cycle but for a held last byte. The parser
//   updates its state in the cycle the byte is accepted, so the first
//   result of a header is valid the cycle after its last byte is accepted,
//   and the results follow at one per cycle while rsp_tready is high.
//   The table of a finished header is copied into the result buffer, so
//   bytes of the next header keep flowing while results are still being
//   played out. Only a last byte has to wait: req_tready drops for it while
//   the buffer still holds results of the previous header, so a header
//   shorter than LEVEL_COUNT bytes can stall on its last byte.
//   When rsp_tready is low the current result holds.
//   Reset clears the parser and empties the result buffer; no clearing
//   pass is needed.
module taxonomy_field_splitter #(
   parameter int MAX_HEADER_BYTES = tfs_pkg::DEF_MAX_HEADER_BYTES,
   parameter int LEVEL_COUNT      = tfs_pkg::DEF_LEVEL_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] header_byte
   input  logic       req_tlast,    // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // [3:0] level_index, [4] level_found, [20:5] name_offset,
   // [36:21] name_length, [37] header_too_long, rest zero
   output logic [tfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic       rsp_tlast     // last_level
);
   import tfs_pkg::*;

   localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

   logic        req_accept;
   logic        rsp_accept;
   logic        emit_last;

   logic [15:0] next_offset [LEVEL_COUNT];
   logic [15:0] next_length [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] next_valid;
   logic        next_overflow;

   logic [15:0] snap_off_ff [LEVEL_COUNT];
   logic [15:0] snap_len_ff [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] snap_vld_ff;
   logic        snap_ovf_ff;
   logic        busy_ff;
   logic [LVL_W-1:0] emit_idx_ff;

   logic        found;
   logic [15:0] out_off;
   logic [15:0] out_len;

   tfs_parser #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
      .LEVEL_COUNT      (LEVEL_COUNT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (req_accept),
      .header_byte   (req_tdata),
      .final_byte    (req_tlast),
      .next_offset   (next_offset),
      .next_length   (next_length),
      .next_valid    (next_valid),
      .next_overflow (next_overflow)
   );

   assign emit_last  = (32'(emit_idx_ff) == LEVEL_COUNT - 1);
   assign rsp_accept = busy_ff && rsp_tready;

   // Hold a last byte until the buffer frees up
   assign req_tready = !req_tlast || !busy_ff || (rsp_tready && emit_last);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         emit_idx_ff <= '0;
      end else if (req_accept && req_tlast) begin
         busy_ff     <= 1'b1;
         emit_idx_ff <= '0;
      end else if (rsp_accept) begin
         if (emit_last) begin
            busy_ff <= 1'b0;
         end else begin
            emit_idx_ff <= emit_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         snap_off_ff <= next_offset;
         snap_len_ff <= next_length;
         snap_vld_ff <= next_valid;
         snap_ovf_ff <= next_overflow;
      end
   end

   always_comb begin
      found   = snap_vld_ff[emit_idx_ff];
      out_off = found ? snap_off_ff[emit_idx_ff] : 16'd0;
      out_len = found ? snap_len_ff[emit_idx_ff] : 16'd0;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = emit_last;
   assign rsp_tdata  = RSP_DATA_W'({snap_ovf_ff, out_len, out_off, found,
                                    4'(emit_idx_ff)});

endmodule

### bench/taxonomy_field_splitter_tb.sv
// Self-checking bench for taxonomy_field_splitter: streams header text through
// the request channel and checks every level result against an in-bench parser.
// Depends on tfs_pkg and the taxonomy_field_splitter RTL.
module taxonomy_field_splitter_tb;
   import tfs_pkg::*;

   localparam int unsigned HDR_MAX        = DEF_MAX_HEADER_BYTES;
   localparam int          LEVELS         = DEF_LEVEL_COUNT;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          PHASE_BYTES    = 40;
   localparam logic [31:0] ATTR_TEXT      = "tax=";
   localparam logic [71:0] LEVEL_TEXT     = "dkpcofgst";

   typedef enum logic [1:0] {EL_START, EL_LETTER, EL_NAME, EL_SKIP} elem_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } hdr_item_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic        too_long;
      logic [15:0] length;
      logic [15:0] offset;
      logic        found;
      logic [3:0]  level;
   } level_word_type;

   typedef struct packed {
      logic           last_level;
      level_word_type word;
   } level_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   taxonomy_field_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   hdr_item_type     header_bytes[$];
   byte unsigned     hdr_build[$];
   level_result_type expected_levels[$];

   int  req_idle_pct    = 0;
   int  rsp_stall_pct   = 0;
   bit  hold_armed      = 1'b0;
   int  hold_count      = 0;
   bit  req_fire        = 1'b0;
   int  idle_cycles     = 0;
   int  errors          = 0;
   int  bytes_queued    = 0;
   int  bytes_taken     = 0;
   int  headers_done    = 0;
   int  results_checked = 0;

   // Parser state mirrored from the block
   int unsigned    hdr_pos;
   bit             at_boundary;
   int unsigned    attr_matched;
   bit             tax_done;
   bit             in_value;
   elem_phase_type el_phase;
   int unsigned    pend_rank;
   int unsigned    rec_rank;
   int unsigned    lvl_offset[16];
   int unsigned    lvl_length[16];
   bit             lvl_seen[16];
   bit             saturated;

   function automatic void clear_parse();
      hdr_pos      = 0;
      at_boundary  = 1'b1;
      attr_matched = 0;
      tax_done     = 1'b0;
      in_value     = 1'b0;
      el_phase     = EL_START;
      pend_rank    = 0;
      rec_rank     = 0;
      saturated    = 1'b0;
      for (int i = 0; i < 16; i++) begin
         lvl_offset[i] = 0;
         lvl_length[i] = 0;
         lvl_seen[i]   = 1'b0;
      end
   endfunction

   // Rank of a level letter, -1 if none; only A..Z fold
   function automatic int rank_of(input logic [7:0] b);
      logic [7:0] low;
      int         r;
      low = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      r   = -1;
      for (int i = 0; i < 9 && i < LEVELS; i++) begin
         if (r < 0 && low == LEVEL_TEXT[71-8*i -: 8]) begin
            r = i;
         end
      end
      return r;
   endfunction

   function automatic void take_header_byte(input logic [7:0] b, input logic last);
      int unsigned      idx;
      int               r;
      level_result_type res;
      if (hdr_pos >= HDR_MAX) begin
         idx       = HDR_MAX;
         saturated = 1'b1;
      end else begin
         idx     = hdr_pos;
         hdr_pos = hdr_pos + 1;
      end
      if (in_value) begin
         if (b == CHAR_SEMI) begin
            in_value = 1'b0;
         end else begin
            case (el_phase)
               EL_START: begin
                  if (b != CHAR_COMMA) begin
                     r = rank_of(b);
                     if (r >= 0) begin
                        pend_rank = r;
                        el_phase  = EL_LETTER;
                     end else begin
                        el_phase = EL_SKIP;
                     end
                  end
               end
               EL_LETTER: begin
                  if (b == CHAR_COLON) begin
                     if (idx + 1 > SAT16) begin
                        lvl_offset[pend_rank] = SAT16;
                        saturated             = 1'b1;
                     end else begin
                        lvl_offset[pend_rank] = idx + 1;
                     end
                     lvl_length[pend_rank] = 0;
                     lvl_seen[pend_rank]   = 1'b1;
                     rec_rank              = pend_rank;
                     el_phase              = EL_NAME;
                  end else if (b == CHAR_COMMA) begin
                     el_phase = EL_START;
                  end else begin
                     el_phase = EL_SKIP;
                  end
               end
               EL_NAME: begin
                  if (b == CHAR_COMMA) begin
                     el_phase = EL_START;
                  end else if (lvl_length[rec_rank] >= SAT16) begin
                     saturated = 1'b1;
                  end else begin
                     lvl_length[rec_rank] = lvl_length[rec_rank] + 1;
                  end
               end
               default: begin
                  if (b == CHAR_COMMA) begin
                     el_phase = EL_START;
                  end
               end
            endcase
         end
      end else if (!tax_done) begin
         if ((at_boundary || attr_matched > 0) && attr_matched < 4 &&
             b == ATTR_TEXT[31-8*attr_matched -: 8]) begin
            attr_matched = attr_matched + 1;
            if (attr_matched == 4) begin
               attr_matched = 0;
               tax_done     = 1'b1;
               in_value     = 1'b1;
               el_phase     = EL_START;
            end
         end else begin
            attr_matched = 0;
         end
         at_boundary = (b == CHAR_SEMI);
      end
      if (last) begin
         for (int k = 0; k < LEVELS; k++) begin
            res                 = '0;
            res.word.level      = 4'(k);
            res.word.found      = lvl_seen[k];
            res.word.offset     = lvl_seen[k] ? lvl_offset[k][15:0] : 16'd0;
            res.word.length     = lvl_seen[k] ? lvl_length[k][15:0] : 16'd0;
            res.word.too_long   = saturated;
            res.last_level      = (k == LEVELS - 1);
            expected_levels.push_back(res);
         end
         clear_parse();
         headers_done++;
      end
   endfunction

   // Move the header under construction to the send queue, last byte marked
   function automatic void flush_header();
      hdr_item_type it;
      for (int i = 0; i < hdr_build.size(); i++) begin
         it.data = hdr_build[i];
         it.last = (i == hdr_build.size() - 1);
         header_bytes.push_back(it);
      end
      bytes_queued += hdr_build.size();
      hdr_build.delete();
   endfunction

   function automatic void add_text(input string s, input bit finish = 1'b0);
      for (int i = 0; i < s.len(); i++) begin
         hdr_build.push_back(s[i]);
      end
      if (finish) begin
         flush_header();
      end
   endfunction

   // Mostly well-formed tax headers with random content; some noise and breakage
   function automatic void queue_random_header();
      int           n_el;
      int           nlen;
      int           li;
      byte unsigned c;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) hdr_build.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) begin
            add_text("id=");
            repeat ($urandom_range(0, 5)) begin
               hdr_build.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
            hdr_build.push_back(CHAR_SEMI);
         end
         case ($urandom_range(7))
            0:       add_text("Tax=");
            1:       add_text("tx=");
            2:       add_text("ttax=");
            default: add_text("tax=");
         endcase
         n_el = $urandom_range(0, 7);
         for (int e = 0; e < n_el; e++) begin
            if ($urandom_range(7) == 0) begin
               hdr_build.push_back(CHAR_COMMA);
            end
            if ($urandom_range(9) < 8) begin
               li = $urandom_range(8);
               c  = LEVEL_TEXT[71-8*li -: 8];
               if ($urandom_range(1)) begin
                  c = c - 8'd32;
               end
            end else begin
               c = 8'($urandom_range(255));
            end
            hdr_build.push_back(c);
            if ($urandom_range(7) != 0) begin
               hdr_build.push_back(CHAR_COLON);
            end else if ($urandom_range(1)) begin
               hdr_build.push_back(8'($urandom_range(255)));
            end
            nlen = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            repeat (nlen) begin
               if ($urandom_range(15) == 0) begin
                  hdr_build.push_back(8'($urandom_range(255)));
               end else begin
                  hdr_build.push_back(8'($urandom_range(8'h61, 8'h7A)));
               end
            end
            if (e < n_el - 1) begin
               hdr_build.push_back(CHAR_COMMA);
            end
         end
         case ($urandom_range(3))
            0:       add_text(";size=7");
            1:       add_text(";tax=s:zz");
            default: ;
         endcase
      end
      flush_header();
   endfunction

   task automatic run_phase(input int req_pct, input int rsp_pct, input int n_bytes);
      int start;
      @(posedge clock);
      req_idle_pct  = req_pct;
      rsp_stall_pct = rsp_pct;
      start         = bytes_queued;
      while (bytes_queued - start < n_bytes) begin
         queue_random_header();
      end
      // hold off until the block has drained completely
      while (header_bytes.size() != 0 || req_tvalid || expected_levels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (header_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= header_bytes[0].data;
            req_tlast  <= header_bytes[0].last;
            header_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with the long hold-off counted here
   always @(negedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: predict on accepted requests, check accepted results, watchdog
   always @(posedge clock) begin
      level_word_type   got;
      level_result_type exp_res;
      if (reset) begin
         req_fire    <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            take_header_byte(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_checked++;
            if (expected_levels.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result: level=%0d found=%0b off=%0d len=%0d long=%0b",
                           got.level, got.found, got.offset, got.length, got.too_long);
               end
            end else begin
               exp_res = expected_levels.pop_front();
               if (got.level !== exp_res.word.level || got.found !== exp_res.word.found ||
                   got.offset !== exp_res.word.offset || got.length !== exp_res.word.length ||
                   got.too_long !== exp_res.word.too_long || got.pad !== 2'b00 ||
                   rsp_tlast !== exp_res.last_level) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("result mismatch: expected level=%0d found=%0b off=%0d len=%0d",
                              exp_res.word.level, exp_res.word.found, exp_res.word.offset,
                              exp_res.word.length);
                     $display("   long=%0b last=%0b; got level=%0d found=%0b off=%0d len=%0d",
                              exp_res.word.too_long, exp_res.last_level, got.level,
                              got.found, got.offset, got.length);
                     $display("   long=%0b last=%0b pad=%b", got.too_long, rsp_tlast, got.pad);
                  end
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("taxonomy_field_splitter: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      clear_parse();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed headers
      add_text("tax=d:Bacteria,k:Fungi,p:Pro,c:Gam,o:Ent,f:Fam,g:Esc,s:coli,t:K12", 1);
      add_text("TAX=d:x", 1);
      add_text("tax=D:A,K:Bb,S:", 1);
      add_text("id;tax=g:ab,,,s:", 1);
      add_text("xtax=d:a", 1);
      add_text("tax=s:a,s:bb;tax=g:c", 1);
      add_text("tax=d", 1);
      add_text("tax=k;size=3", 1);
      add_text("tax=x:a,d,k:,,p:q", 1);
      add_text("t", 1);
      add_text(";", 1);
      add_text("tax=", 1);
      add_text("tatax=d:a", 1);
      add_text("a;tax=dd:q,@:1,[:2,o:", 1);
      add_text("size=1;TAX=s:a;tax=G:x;tax=p:y", 1);
      add_text("tax=");
      hdr_build.push_back(8'hC4);
      hdr_build.push_back(CHAR_COLON);
      hdr_build.push_back(8'h00);
      add_text(",f:");
      hdr_build.push_back(8'hFF);
      hdr_build.push_back(8'h80);
      flush_header();

      run_phase(0, 0, PHASE_BYTES);
      run_phase(88, 0, PHASE_BYTES);
      run_phase(0, 88, PHASE_BYTES);
      run_phase(18, 18, PHASE_BYTES);

      // Receiver holds off while requests keep coming, so the block backs up
      @(posedge clock);
      hold_armed = 1'b1;
      run_phase(0, 0, PHASE_BYTES);
      while (hold_count < HOLD_CYCLES) @(posedge clock);

      repeat (20) @(posedge clock);
      if (expected_levels.size() != 0) begin
         errors += expected_levels.size();
         $display("%0d expected results never arrived", expected_levels.size());
      end
      $display("covered %0d headers (%0d bytes, directed and random), %0d results checked,",
               headers_done, bytes_taken, results_checked);
      $display("under sender gaps, receiver stalls and a %0d-cycle receiver hold-off", HOLD_CYCLES);
      if (errors == 0) begin
         $display("taxonomy_field_splitter: match");
      end else begin
         $display("taxonomy_field_splitter: mismatch");
      end
      $finish;
   end

endmodule
